// ===== rtl/tvc_pkg.sv =====
// shared types and constants for the triangle visibility cull block
package tvc_pkg;

    localparam logic [2:0] CFG_CAM_X     = 3'd0;
    localparam logic [2:0] CFG_CAM_Y     = 3'd1;
    localparam logic [2:0] CFG_CAM_Z     = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR  = 3'd3;
    localparam logic [2:0] CFG_CONE_COS  = 3'd4;
    localparam logic [2:0] CFG_NEAR      = 3'd5;
    localparam logic [2:0] CFG_DISABLE   = 3'd6;

    localparam logic [1:0] REASON_VISIBLE = 2'd0;
    localparam logic [1:0] REASON_BACK    = 2'd1;
    localparam logic [1:0] REASON_CONE    = 2'd2;

    // cos(0.6*pi) in q2.14 scaled to q4.28
    localparam logic signed [34:0] FRONT_LIMIT = -35'sd82952192;
    // squared raw length below this means the vertex sits at the camera
    localparam logic [65:0] AT_CAMERA_SQ = 66'd4295;

    // per vertex flags handed from the front part to the back part
    typedef struct packed {
        logic front;
        logic incone;
        logic last;
    } t_vtx_flags;

endpackage

// ===== rtl/tvc_front.sv =====
// vertex classification pipeline: distance, facing and cone tests
module tvc_front
    import tvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic               i_last_vertex,
    input  logic signed [31:0] i_cam_x,
    input  logic signed [31:0] i_cam_y,
    input  logic signed [31:0] i_cam_z,
    input  logic [47:0]        i_view_dir,
    input  logic signed [15:0] i_cone_cos,
    input  logic [30:0]        i_near,
    output logic               o_valid,
    input  logic               i_stall,
    output t_vtx_flags         o_flags
);

    // stage a: difference vectors
    logic               r_va;
    logic signed [32:0] r_t [3];
    logic signed [15:0] r_n [3];
    logic               r_lasta;
    // stage b: products
    logic               r_vb;
    logic [63:0]        r_sq [3];
    logic signed [48:0] r_cp [3];
    logic signed [32:0] r_np [3];
    logic [31:0]        r_c2;
    logic               r_lastb;
    // stage c: sums
    logic               r_vc;
    logic [65:0]        r_sumsq;
    logic signed [50:0] r_cdot;
    logic signed [34:0] r_ndot;
    logic [63:0]        r_m2 [3];
    logic [61:0]        r_near2;
    logic               r_lastc;
    // stage d: cone square partial products
    logic               r_vd;
    logic [65:0]        r_sumsq_d;
    logic signed [50:0] r_cdot_d;
    logic               r_front_d;
    logic               r_near_d;
    logic [63:0]        r_csq_lo [3];
    logic [63:0]        r_csq_hi [3];
    logic [49:0]        r_cmag;
    logic               r_lastd;
    // stage e
    logic               r_ve;
    logic               r_incone_pre;
    logic               r_front_e;
    logic               r_near_e;
    logic               r_atcam;
    logic [97:0]        r_csq;
    logic [49:0]        r_dp_hh;
    logic [49:0]        r_dp_hl;
    logic [49:0]        r_dp_ll;
    logic               r_cpos;
    logic               r_cnonneg;
    logic               r_laste;

    logic signed [15:0] w_d [3];
    logic               w_adv;
    logic signed [15:0] w_c;
    logic [15:0]        w_cmag;
    logic [99:0]        w_dsq;

    assign w_d[0] = i_view_dir[47:32];
    assign w_d[1] = i_view_dir[31:16];
    assign w_d[2] = i_view_dir[15:0];
    assign w_c    = i_cone_cos;
    assign w_cmag = w_c[15] ? 16'(-w_c) : w_c;

    // whole pipe moves together when output is free
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    function automatic logic [31:0] f_mag(input logic signed [32:0] v);
        logic signed [32:0] a;
        a = v[32] ? -v : v;
        return a[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0; r_ve <= 1'b0;
        end else if (w_adv) begin
            r_va <= i_valid; r_vb <= r_va; r_vc <= r_vb; r_vd <= r_vc; r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t[0] <= 33'(i_vertex_x) - 33'(i_cam_x);
            r_t[1] <= 33'(i_vertex_y) - 33'(i_cam_y);
            r_t[2] <= 33'(i_vertex_z) - 33'(i_cam_z);
            r_n[0] <= i_normal_x; r_n[1] <= i_normal_y; r_n[2] <= i_normal_z;
            r_lasta <= i_last_vertex;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 64'(f_mag(r_t[k])) * 64'(f_mag(r_t[k]));
                r_cp[k] <= 49'(r_t[k]) * 49'(w_d[k]);
                r_np[k] <= -(33'(r_n[k]) * 33'(w_d[k]));
            end
            r_c2    <= 32'(w_cmag) * 32'(w_cmag);
            r_lastb <= r_lasta;
            r_sumsq <= 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]);
            r_cdot  <= 51'(r_cp[0]) + 51'(r_cp[1]) + 51'(r_cp[2]);
            r_ndot  <= 35'(r_np[0]) + 35'(r_np[1]) + 35'(r_np[2]);
            for (int k = 0; k < 3; k++) r_m2[k] <= r_sq[k];
            r_near2 <= 62'(i_near) * 62'(i_near);
            r_lastc <= r_lastb;
            r_sumsq_d <= r_sumsq;
            r_cdot_d  <= r_cdot;
            r_near_d  <= r_sumsq <= 66'(r_near2);
            r_front_d <= r_ndot >= FRONT_LIMIT;
            // c^2 * m^2 split into two 32 by 32 products per axis
            for (int k = 0; k < 3; k++) begin
                r_csq_lo[k] <= 64'(r_c2) * 64'(r_m2[k][31:0]);
                r_csq_hi[k] <= 64'(r_c2) * 64'(r_m2[k][63:32]);
            end
            r_cmag    <= r_cdot[50] ? 50'(-r_cdot) : r_cdot[49:0];
            r_lastd   <= r_lastc;
            r_front_e <= r_near_d || r_front_d;
            r_near_e  <= r_near_d;
            r_atcam   <= r_sumsq_d < AT_CAMERA_SQ;
            r_incone_pre <= w_d[2] >= w_c;
            r_csq   <= (98'(r_csq_hi[0]) << 32) + 98'(r_csq_lo[0])
                     + (98'(r_csq_hi[1]) << 32) + 98'(r_csq_lo[1])
                     + (98'(r_csq_hi[2]) << 32) + 98'(r_csq_lo[2]);
            // |cdot|^2 from 25 bit halves
            r_dp_hh <= 50'(r_cmag[49:25]) * 50'(r_cmag[49:25]);
            r_dp_hl <= 50'(r_cmag[49:25]) * 50'(r_cmag[24:0]);
            r_dp_ll <= 50'(r_cmag[24:0]) * 50'(r_cmag[24:0]);
            r_cpos  <= w_c > 16'sd0;
            r_cnonneg <= !r_cdot_d[50];
            r_laste <= r_lastd;
        end
    end

    assign w_dsq = (100'(r_dp_hh) << 50) + (100'(r_dp_hl) << 26) + 100'(r_dp_ll);

    logic w_incone;
    always_comb begin
        if (r_atcam)
            w_incone = r_incone_pre;
        else if (!r_cpos)
            w_incone = r_cnonneg || (w_dsq <= 100'(r_csq));
        else
            w_incone = r_cnonneg && (w_dsq >= 100'(r_csq));
    end

    assign o_valid        = r_ve;
    assign o_flags.front  = r_front_e;
    assign o_flags.incone = r_near_e || w_incone;
    assign o_flags.last   = r_laste;

endmodule

// ===== rtl/tvc_fifo.sv =====
// short flag queue between classifier and accumulator
module tvc_fifo
    import tvc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_vtx_flags i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_vtx_flags o_data
);

    t_vtx_flags r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = r_cnt == 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/tvc_back.sv =====
// triangle accumulator and result register
module tvc_back
    import tvc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_vtx_flags i_flags,
    input  logic       i_disable,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_visible,
    output logic [1:0] o_cull_reason
);

    logic       r_any_front, r_any_cone, r_valid, r_visible;
    logic [1:0] r_reason;
    logic       w_take, w_front, w_cone;

    assign o_stall = r_valid && i_stall;
    assign w_take  = i_valid && !o_stall;
    assign w_front = r_any_front || i_flags.front;
    assign w_cone  = r_any_cone || i_flags.incone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_front <= 1'b0; r_any_cone <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            if (w_take) begin
                r_any_front <= i_flags.last ? 1'b0 : w_front;
                r_any_cone  <= i_flags.last ? 1'b0 : w_cone;
                if (i_flags.last) r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_flags.last) begin
            if (i_disable || (w_front && w_cone)) begin
                r_visible <= 1'b1; r_reason <= REASON_VISIBLE;
            end else if (!w_front) begin
                r_visible <= 1'b0; r_reason <= REASON_BACK;
            end else begin
                r_visible <= 1'b0; r_reason <= REASON_CONE;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_visible     = r_visible;
    assign o_cull_reason = r_reason;

endmodule

// ===== rtl/triangle_visibility_cull_core.sv =====
// top level of the triangle visibility cull block
//
// vertices arrive one transaction each on the input channel (valid/stall),
// with a q16.16 position, a q2.14 normal and a last-vertex mark. a result
// transaction (visible, cull_reason) leaves only for a marked last vertex
//
// the front part is a five stage pipeline: subtract camera, form products,
// sum them, form the cone square partial products, sum them and compare. it
// takes one vertex per cycle while not stalled. its flags go through a four
// entry queue to the back part, which ORs facing and cone flags over the
// triangle and registers the verdict
//
// a result passes the front stages, the queue and the result register;
// throughput is one vertex per cycle while the output is taken
//
// reset (synchronous, active low) loads register defaults and drops all
// in-flight transactions. a stalled receiver holds the result register, the
// queue fills, then the front pipeline freezes and stalls the sender
//
// configuration write port: user writes only while block idle, not enforced
module triangle_visibility_cull_core
    import tvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    input  logic signed [31:0] i_vertex_z,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_visible,
    output logic [1:0]         o_cull_reason
);

    // configuration registers
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic [47:0]        r_view_dir;
    logic signed [15:0] r_cone_cos;
    logic [30:0]        r_near;
    logic               r_disable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0; r_cam_y <= '0; r_cam_z <= '0;
            r_view_dir <= 48'd16384;
            r_cone_cos <= 16'sd11585;
            r_near     <= '0;
            r_disable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAM_X:    r_cam_x    <= i_cfg_data[31:0];
                CFG_CAM_Y:    r_cam_y    <= i_cfg_data[31:0];
                CFG_CAM_Z:    r_cam_z    <= i_cfg_data[31:0];
                CFG_VIEW_DIR: r_view_dir <= i_cfg_data;
                CFG_CONE_COS: r_cone_cos <= i_cfg_data[15:0];
                CFG_NEAR:     r_near     <= i_cfg_data[30:0];
                CFG_DISABLE:  r_disable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front pipeline to queue
    logic       w_fv, w_fs;
    t_vtx_flags w_ff;
    // queue to back part
    logic       w_qv, w_qs;
    t_vtx_flags w_qf;

    tvc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_vertex_x, .i_vertex_y, .i_vertex_z,
        .i_normal_x, .i_normal_y, .i_normal_z, .i_last_vertex,
        .i_cam_x(r_cam_x), .i_cam_y(r_cam_y), .i_cam_z(r_cam_z),
        .i_view_dir(r_view_dir), .i_cone_cos(r_cone_cos), .i_near(r_near),
        .o_valid(w_fv), .i_stall(w_fs), .o_flags(w_ff)
    );

    tvc_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(w_fv), .o_stall(w_fs), .i_data(w_ff),
        .o_valid(w_qv), .i_stall(w_qs), .o_data(w_qf)
    );

    // the disable bit is read when the last vertex reaches the accumulator
    tvc_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_stall(w_qs), .i_flags(w_qf),
        .i_disable(r_disable),
        .o_valid, .i_stall, .o_visible, .o_cull_reason
    );

endmodule
